### design/cse_pkg.sv
// Shared types, constants and arithmetic helpers for the curve segment evaluator.
package cse_pkg;

	localparam int NSTG    = 9;
	localparam int COORD_W = 32;
	localparam int U_W     = 17;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = DIFF_W + U_W + 1;
	localparam int H_W     = 18;
	localparam int WIDE_W  = 52;
	localparam int SUM_W   = 53;
	localparam int RND_W   = SUM_W - 16;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [U_W-1:0]            param_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [H_W-1:0]     weight_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [RND_W-1:0]   rnd_t;
	typedef logic [1:0]                mode_t;

	localparam mode_t MODE_LINEAR  = 2'd0;
	localparam mode_t MODE_BEZIER  = 2'd1;
	localparam mode_t MODE_HERMITE = 2'd2;

	localparam param_t U_ONE     = param_t'(65536);
	localparam prod_t  HALF16_P  = prod_t'(32768);
	localparam sum_t   HALF16_S  = sum_t'(32768);
	localparam wide_t  HALF32_W  = wide_t'(64'd2147483648);
	localparam rnd_t   COORD_MAX = rnd_t'(64'sd2147483647);
	localparam rnd_t   COORD_MIN = rnd_t'(-64'sd2147483648);

	typedef struct packed {
		logic [NSTG-1:0] en;
	} pipe_ctrl_t;

	function automatic param_t clamp_u(param_t u);
		return (u > U_ONE) ? U_ONE : u;
	endfunction

	function automatic diff_t sub_coord(coord_t p, coord_t q);
		return diff_t'(q) - diff_t'(p);
	endfunction

	function automatic prod_t mul_u(diff_t d, param_t u);
		logic signed [U_W:0] us;
		us = $signed({1'b0, u});
		return prod_t'(d * us);
	endfunction

	function automatic coord_t lerp_fin(coord_t p, prod_t m);
		prod_t                    t;
		logic signed [DIFF_W+1:0] r;
		logic signed [DIFF_W+1:0] s;
		t = m + HALF16_P;
		r = (DIFF_W + 2)'(t >>> 16);
		s = r + (DIFF_W + 2)'(p);
		return s[COORD_W-1:0];
	endfunction

endpackage

### design/cse_in_if.sv
// Input channel carrying one curve sample request per transaction.
interface cse_in_if;
	import cse_pkg::*;

	logic   valid;
	logic   ready;
	coord_t point_a;
	coord_t point_b;
	coord_t point_c;
	coord_t point_d;
	param_t param_u;

	modport source (output valid, output point_a, output point_b, output point_c,
		output point_d, output param_u, input ready);
	modport sink (input valid, input point_a, input point_b, input point_c,
		input point_d, input param_u, output ready);
endinterface

### design/cse_out_if.sv
// Output channel carrying one evaluated coordinate per transaction.
interface cse_out_if;
	import cse_pkg::*;

	logic   valid;
	logic   ready;
	coord_t curve_value;
	logic   saturated;

	modport source (output valid, output curve_value, output saturated, input ready);
	modport sink (input valid, input curve_value, input saturated, output ready);
endinterface

### design/cse_pipe_ctrl.sv
// Stage valid bits, per-stage load enables and the mode that travels with each transaction.
module cse_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  cse_pkg::mode_t      mode_in,
	output cse_pkg::mode_t      mode_out,
	output cse_pkg::pipe_ctrl_t ctl
);
	import cse_pkg::*;

	logic [NSTG-1:0] stage_valid_q;
	mode_t           stage_mode_q [NSTG];
	logic            in_acc;
	logic            out_acc;

	always_comb begin
		ctl.en[NSTG-1] = !stage_valid_q[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			ctl.en[k] = !stage_valid_q[k] || ctl.en[k+1];
		end
	end

	assign in_ready  = ctl.en[0];
	assign out_valid = stage_valid_q[NSTG-1];
	assign mode_out  = stage_mode_q[NSTG-1];
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (ctl.en[0]) begin
				stage_valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (ctl.en[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			stage_mode_q[0] <= mode_in;
		end
		for (int k = 1; k < NSTG; k++) begin
			if (ctl.en[k]) begin
				stage_mode_q[k] <= stage_mode_q[k-1];
			end
		end
	end

	// A stalled output only lets a new transaction in when a bubble is present.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!ctl.en[NSTG-1] && in_ready) |-> !(&stage_valid_q))
		else $error("input accepted while the full pipeline is stalled");

	// Transactions in flight change only by what enters and leaves.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(stage_valid_q) + int'($past(out_acc))
			== $past($countones(stage_valid_q)) + int'($past(in_acc))))
		else $error("transaction lost or duplicated inside the pipeline");

	// A held result keeps the mode it was computed under.
	assert property (@(posedge clk) disable iff (!arst_n)
		(stage_valid_q[NSTG-1] && !out_ready) |=>
			(stage_valid_q[NSTG-1] && $stable(stage_mode_q[NSTG-1])))
		else $error("stalled result changed its mode");

endmodule

### design/cse_bezier_path.sv
// Linear and de Casteljau cubic datapath: three levels of subtract, multiply and round-add stages.
module cse_bezier_path (
	input  logic                clk,
	input  cse_pkg::pipe_ctrl_t ctl,
	input  cse_pkg::coord_t     point_a,
	input  cse_pkg::coord_t     point_b,
	input  cse_pkg::coord_t     point_c,
	input  cse_pkg::coord_t     point_d,
	input  cse_pkg::param_t     param_u,
	output cse_pkg::coord_t     lin_value,
	output cse_pkg::coord_t     cub_value
);
	import cse_pkg::*;

	param_t u_s1, u_s2, u_s3, u_s4, u_s5, u_s6, u_s7;
	coord_t a_s1, b_s1, c_s1, a_s2, b_s2, c_s2;
	diff_t  d0_s1, d1_s1, d2_s1;
	prod_t  m0_s2, m1_s2, m2_s2;
	coord_t p01_s3, p11_s3, p21_s3;
	diff_t  e0_s4, e1_s4;
	coord_t p01_s4, p11_s4, p01_s5, p11_s5;
	prod_t  n0_s5, n1_s5;
	coord_t p02_s6, p12_s6, lin_s6;
	diff_t  f_s7;
	coord_t p02_s7, lin_s7, p02_s8, lin_s8;
	prod_t  g_s8;
	coord_t cub_s9, lin_s9;

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			u_s1  <= clamp_u(param_u);
			a_s1  <= point_a;
			b_s1  <= point_b;
			c_s1  <= point_c;
			d0_s1 <= sub_coord(point_a, point_b);
			d1_s1 <= sub_coord(point_b, point_c);
			d2_s1 <= sub_coord(point_c, point_d);
		end
		if (ctl.en[1]) begin
			m0_s2 <= mul_u(d0_s1, u_s1);
			m1_s2 <= mul_u(d1_s1, u_s1);
			m2_s2 <= mul_u(d2_s1, u_s1);
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			c_s2  <= c_s1;
			u_s2  <= u_s1;
		end
		if (ctl.en[2]) begin
			p01_s3 <= lerp_fin(a_s2, m0_s2);
			p11_s3 <= lerp_fin(b_s2, m1_s2);
			p21_s3 <= lerp_fin(c_s2, m2_s2);
			u_s3   <= u_s2;
		end
		if (ctl.en[3]) begin
			e0_s4  <= sub_coord(p01_s3, p11_s3);
			e1_s4  <= sub_coord(p11_s3, p21_s3);
			p01_s4 <= p01_s3;
			p11_s4 <= p11_s3;
			u_s4   <= u_s3;
		end
		if (ctl.en[4]) begin
			n0_s5  <= mul_u(e0_s4, u_s4);
			n1_s5  <= mul_u(e1_s4, u_s4);
			p01_s5 <= p01_s4;
			p11_s5 <= p11_s4;
			u_s5   <= u_s4;
		end
		if (ctl.en[5]) begin
			p02_s6 <= lerp_fin(p01_s5, n0_s5);
			p12_s6 <= lerp_fin(p11_s5, n1_s5);
			lin_s6 <= p01_s5;
			u_s6   <= u_s5;
		end
		if (ctl.en[6]) begin
			f_s7   <= sub_coord(p02_s6, p12_s6);
			p02_s7 <= p02_s6;
			lin_s7 <= lin_s6;
			u_s7   <= u_s6;
		end
		if (ctl.en[7]) begin
			g_s8   <= mul_u(f_s7, u_s7);
			p02_s8 <= p02_s7;
			lin_s8 <= lin_s7;
		end
		if (ctl.en[8]) begin
			cub_s9 <= lerp_fin(p02_s8, g_s8);
			lin_s9 <= lin_s8;
		end
	end

	assign lin_value = lin_s9;
	assign cub_value = cub_s9;

endmodule

### design/cse_hermite_path.sv
// Hermite datapath: basis weights from u, weighted sum, rounding and saturation.
module cse_hermite_path (
	input  logic                clk,
	input  cse_pkg::pipe_ctrl_t ctl,
	input  cse_pkg::coord_t     point_a,
	input  cse_pkg::coord_t     point_b,
	input  cse_pkg::coord_t     point_c,
	input  cse_pkg::coord_t     point_d,
	input  cse_pkg::param_t     param_u,
	output cse_pkg::coord_t     herm_value,
	output logic                herm_sat
);
	import cse_pkg::*;

	param_t      u_c;
	param_t      u_s1, u_s2;
	logic [32:0] u2_s1, u2_s2;
	logic [48:0] u3_s2;
	coord_t      a_s1, a_s2, a_s3, a_s4;
	coord_t      c_s1, c_s2, c_s3, d_s1, d_s2, d_s3;
	diff_t       dab_s1, dab_s2, dab_s3;
	weight_t     h01_s3, h10_s3, h11_s3;
	prod_t       p1_s4, p2_s4, p3_s4;
	sum_t        s1_s5, s2_s5, sum_s6;
	rnd_t        r_s7;
	coord_t      val_s8, val_s9;
	logic        sat_s8, sat_s9;
	wide_t       x1, x2, x3, t01, t10, t11;
	sum_t        a_sh;
	sum_t        r_full;

	assign u_c = clamp_u(param_u);

	always_comb begin
		x1     = $signed({3'b000, u_s2, 32'd0});
		x2     = $signed({3'b000, u2_s2, 16'd0});
		x3     = $signed({3'b000, u3_s2});
		t01    = x2 + x2 + x2 - x3 - x3 + HALF32_W;
		t10    = x3 - x2 - x2 + x1 + HALF32_W;
		t11    = x3 - x2 + HALF32_W;
		a_sh   = sum_t'($signed({a_s4, 16'd0}));
		r_full = (sum_s6 + HALF16_S) >>> 16;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			u_s1   <= u_c;
			u2_s1  <= 33'(u_c * u_c);
			a_s1   <= point_a;
			c_s1   <= point_c;
			d_s1   <= point_d;
			dab_s1 <= sub_coord(point_a, point_b);
		end
		if (ctl.en[1]) begin
			u3_s2  <= 49'(u2_s1 * u_s1);
			u2_s2  <= u2_s1;
			u_s2   <= u_s1;
			a_s2   <= a_s1;
			c_s2   <= c_s1;
			d_s2   <= d_s1;
			dab_s2 <= dab_s1;
		end
		if (ctl.en[2]) begin
			h01_s3 <= H_W'(t01 >>> 32);
			h10_s3 <= H_W'(t10 >>> 32);
			h11_s3 <= H_W'(t11 >>> 32);
			a_s3   <= a_s2;
			c_s3   <= c_s2;
			d_s3   <= d_s2;
			dab_s3 <= dab_s2;
		end
		if (ctl.en[3]) begin
			p1_s4 <= prod_t'(dab_s3 * h01_s3);
			p2_s4 <= prod_t'(c_s3 * h10_s3);
			p3_s4 <= prod_t'(d_s3 * h11_s3);
			a_s4  <= a_s3;
		end
		if (ctl.en[4]) begin
			s1_s5 <= a_sh + sum_t'(p1_s4);
			s2_s5 <= sum_t'(p2_s4) + sum_t'(p3_s4);
		end
		if (ctl.en[5]) begin
			sum_s6 <= s1_s5 + s2_s5;
		end
		if (ctl.en[6]) begin
			r_s7 <= RND_W'(r_full);
		end
		if (ctl.en[7]) begin
			if (r_s7 > COORD_MAX) begin
				val_s8 <= COORD_MAX[COORD_W-1:0];
				sat_s8 <= 1'b1;
			end else if (r_s7 < COORD_MIN) begin
				val_s8 <= COORD_MIN[COORD_W-1:0];
				sat_s8 <= 1'b1;
			end else begin
				val_s8 <= r_s7[COORD_W-1:0];
				sat_s8 <= 1'b0;
			end
		end
		if (ctl.en[8]) begin
			val_s9 <= val_s8;
			sat_s9 <= sat_s8;
		end
	end

	assign herm_value = val_s9;
	assign herm_sat   = sat_s9;

endmodule

### design/curve_segment_evaluator.sv
// Curve segment evaluator top level: mode register, pipeline control, datapaths, result select.
// An accepted transaction reaches its result at the output register once it has passed every stage.
// Throughput is one transaction per cycle while the output is ready; the chain of three
// interpolation levels, each a subtract, a multiply and a round-and-add stage, sets the depth.
// A stalled output holds the pipeline from the last stage backward; bubbles still fill.
// Reset clears all stage valid bits and sets curve_mode to cubic Bezier; no clearing pass.
module curve_segment_evaluator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  cse_pkg::mode_t cfg_wr_data,
	cse_in_if.sink         sample,
	cse_out_if.source      result
);
	import cse_pkg::*;

	mode_t      curve_mode_q;
	mode_t      mode_out;
	pipe_ctrl_t ctl;
	coord_t     lin_value;
	coord_t     cub_value;
	coord_t     herm_value;
	logic       herm_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= MODE_BEZIER;
		end else if (cfg_wr_en) begin
			curve_mode_q <= cfg_wr_data;
		end
	end

	cse_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.mode_in   (curve_mode_q),
		.mode_out  (mode_out),
		.ctl       (ctl)
	);

	cse_bezier_path u_bezier (
		.clk       (clk),
		.ctl       (ctl),
		.point_a   (sample.point_a),
		.point_b   (sample.point_b),
		.point_c   (sample.point_c),
		.point_d   (sample.point_d),
		.param_u   (sample.param_u),
		.lin_value (lin_value),
		.cub_value (cub_value)
	);

	cse_hermite_path u_hermite (
		.clk        (clk),
		.ctl        (ctl),
		.point_a    (sample.point_a),
		.point_b    (sample.point_b),
		.point_c    (sample.point_c),
		.point_d    (sample.point_d),
		.param_u    (sample.param_u),
		.herm_value (herm_value),
		.herm_sat   (herm_sat)
	);

	always_comb begin
		case (mode_out)
			MODE_LINEAR: begin
				result.curve_value = lin_value;
				result.saturated   = 1'b0;
			end
			MODE_HERMITE: begin
				result.curve_value = herm_value;
				result.saturated   = herm_sat;
			end
			default: begin
				result.curve_value = cub_value;
				result.saturated   = 1'b0;
			end
		endcase
	end

endmodule
